### design/nasc_pkg.sv
// Shared types, codes and helpers for the nested array shape checker.
package nasc_pkg;

    // Default limits
    localparam int MAX_DIMS_DEF  = 8;
    localparam int MAX_ELEMS_DEF = 65536;

    // Field widths of the token and result channels
    localparam int KIND_W  = 3;
    localparam int ELEM_W  = 64;
    localparam int IDX_W   = 16;
    localparam int DIMC_W  = 4;
    localparam int TOTAL_W = 17;

    // Per-level counters saturate at all ones
    localparam int CNT_W = 32;

    // IEEE double exponent field
    localparam int EXP_LO = 52;
    localparam int EXP_HI = 62;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_COMMA = 3'd2,
        KIND_ELEM  = 3'd3,
        KIND_END   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UNEXPECTED = 3'd1,
        ST_DIMS       = 3'd2,
        ST_ELEMS      = 3'd3,
        ST_SHAPE      = 3'd4,
        ST_NONFINITE  = 3'd5,
        ST_EARLY_END  = 3'd6,
        ST_EMPTY      = 3'd7
    } t_status;

    // Saturating increment of a level count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == {CNT_W{1'b1}}) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
        return r;
    endfunction

endpackage

### design/nested_array_shape_checker.sv
// Top level of the nested array shape checker.
//
// Usage: a lexer feeds one token per transfer on the input channel
// (i_in_valid / o_in_ready, kind plus raw double bits). Each token yields
// exactly one result on the output channel (o_out_valid / i_out_ready):
// a status code, an optional element pass-through with its flat index,
// a done flag, and the running dimension and element counts.
// The token is held in the input register, then its result is loaded into
// the result register once that register is free or being drained.
// Throughput: one token per cycle while the receiver does not stall;
// the shape state is updated by combinational logic between the two
// registers, with the nesting counts held in a push/pop shift stack.
// Reset clears the pipeline and the parse control state; counts and lengths
// are written before they are read, so no clearing pass is needed.
// When the receiver stalls, the result register holds its value and the
// input register takes one more token, after which o_in_ready drops.
// After a completed literal or any error the parse state returns to its
// reset values, ready for the next literal.
module nested_array_shape_checker #(
    parameter int MAX_DIMS  = nasc_pkg::MAX_DIMS_DEF,
    parameter int MAX_ELEMS = nasc_pkg::MAX_ELEMS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // token channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [nasc_pkg::KIND_W-1:0]  i_token_kind,
    input  logic [nasc_pkg::ELEM_W-1:0]  i_element_bits,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_status,
    output logic                         o_element_valid,
    output logic [nasc_pkg::ELEM_W-1:0]  o_element_out,
    output logic [nasc_pkg::IDX_W-1:0]   o_element_index,
    output logic                         o_literal_done,
    output logic [nasc_pkg::DIMC_W-1:0]  o_dim_count,
    output logic [nasc_pkg::TOTAL_W-1:0] o_total_items
);

    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam int LW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int TW = $clog2(MAX_ELEMS + 1);
    localparam int CW = nasc_pkg::CNT_W;

    // Input register
    logic                         r_in_vld;
    logic [nasc_pkg::KIND_W-1:0]  r_in_kind;
    logic [nasc_pkg::ELEM_W-1:0]  r_in_bits;

    // Parse state
    logic [DW-1:0]       r_depth, n_depth;
    logic [DW-1:0]       r_dims, n_dims;
    logic                r_frozen, n_frozen;
    logic                r_want, n_want;
    logic [TW-1:0]       r_total, n_total;
    logic [CW-1:0]       r_cnt [MAX_DIMS];   // r_cnt[0] is the innermost open level
    logic [CW-1:0]       r_len [MAX_DIMS];
    logic [MAX_DIMS-1:0] r_known;

    // Result register
    logic                         r_out_vld;
    nasc_pkg::t_status            r_status, n_status;
    logic                         r_elem_vld, n_elem_vld;
    logic [nasc_pkg::ELEM_W-1:0]  r_elem, n_elem;
    logic [nasc_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                         r_done, n_done;
    logic [nasc_pkg::DIMC_W-1:0]  r_dimc, n_dimc;
    logic [nasc_pkg::TOTAL_W-1:0] r_tot, n_tot;

    // Control for the count stack and length table
    logic          w_adv;
    logic          w_push, w_pop, w_bump, w_learn;
    logic [LW-1:0] w_lvl;
    logic [CW-1:0] w_below;
    logic [31:0]   w_total_ext;
    logic [31:0]   w_ntotal_ext;
    logic [31:0]   w_dims_ext;

    // Handshake: advance when the result register is free or being drained
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;

    // Entry under the top of the stack
    generate
        if (MAX_DIMS > 1) begin : g_below
            assign w_below = r_cnt[1];
        end else begin : g_nobelow
            assign w_below = '0;
        end
    endgenerate

    assign w_lvl        = LW'(r_depth - DW'(1));
    assign w_total_ext  = 32'(r_total);
    assign w_ntotal_ext = 32'(n_total);
    assign w_dims_ext   = 32'(n_dims);

    // Token decode and next-state logic
    always_comb begin
        n_depth    = r_depth;
        n_dims     = r_dims;
        n_frozen   = r_frozen;
        n_want     = r_want;
        n_total    = r_total;
        n_status   = nasc_pkg::ST_OK;
        n_elem_vld = 1'b0;
        n_elem     = '0;
        n_idx      = '0;
        n_done     = 1'b0;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        w_bump     = 1'b0;
        w_learn    = 1'b0;

        if (r_depth == '0) begin
            if (r_in_kind == nasc_pkg::KIND_OPEN) begin
                n_depth = DW'(1);
                n_dims  = DW'(1);
                w_push  = 1'b1;
            end else begin
                n_status = nasc_pkg::ST_UNEXPECTED;
            end
        end else begin
            unique case (r_in_kind)
                nasc_pkg::KIND_OPEN: begin
                    if (r_want) begin
                        n_status = nasc_pkg::ST_UNEXPECTED;
                    end else if (r_depth >= DW'(MAX_DIMS)) begin
                        n_status = nasc_pkg::ST_DIMS;
                    end else begin
                        w_push  = 1'b1;
                        n_depth = r_depth + DW'(1);
                        if (n_depth > r_dims) begin
                            if (r_frozen) n_status = nasc_pkg::ST_SHAPE;
                            else          n_dims   = n_depth;
                        end
                    end
                end
                nasc_pkg::KIND_CLOSE: begin
                    if (r_cnt[0] != '0 && !r_want) begin
                        n_status = nasc_pkg::ST_UNEXPECTED;
                    end else begin
                        n_depth = r_depth - DW'(1);
                        w_pop   = 1'b1;
                        // first closed subarray at a level sets its length
                        if (!r_known[w_lvl]) begin
                            w_learn = 1'b1;
                        end else if (r_cnt[0] != r_len[w_lvl]) begin
                            n_status = nasc_pkg::ST_SHAPE;
                        end
                        n_want = 1'b1;
                        if (n_status == nasc_pkg::ST_OK && n_depth == '0) begin
                            n_done = 1'b1;
                            if (r_total == '0) n_status = nasc_pkg::ST_EMPTY;
                        end
                    end
                end
                nasc_pkg::KIND_COMMA: begin
                    if (!r_want) n_status = nasc_pkg::ST_UNEXPECTED;
                    else         n_want   = 1'b0;
                end
                nasc_pkg::KIND_ELEM: begin
                    if (&r_in_bits[nasc_pkg::EXP_HI:nasc_pkg::EXP_LO]) begin
                        n_status = nasc_pkg::ST_NONFINITE;
                    end else if (r_want) begin
                        n_status = nasc_pkg::ST_UNEXPECTED;
                    end else if (r_total >= TW'(MAX_ELEMS)) begin
                        n_status = nasc_pkg::ST_ELEMS;
                    end else begin
                        n_frozen = 1'b1;
                        if (r_depth != r_dims) begin
                            n_status = nasc_pkg::ST_SHAPE;
                        end else begin
                            n_elem_vld = 1'b1;
                            n_elem     = r_in_bits;
                            n_idx      = w_total_ext[nasc_pkg::IDX_W-1:0];
                            n_total    = r_total + TW'(1);
                            w_bump     = 1'b1;
                            n_want     = 1'b1;
                        end
                    end
                end
                nasc_pkg::KIND_END: begin
                    n_status = nasc_pkg::ST_EARLY_END;
                end
                default: begin
                    n_status = nasc_pkg::ST_UNEXPECTED;
                end
            endcase
        end

        if (n_status != nasc_pkg::ST_OK) n_done = 1'b1;

        // counts reported before the end-of-literal clear
        n_dimc = w_dims_ext[nasc_pkg::DIMC_W-1:0];
        n_tot  = w_ntotal_ext[nasc_pkg::TOTAL_W-1:0];
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_kind <= i_token_kind;
            r_in_bits <= i_element_bits;
        end
    end

    // Parse control state, cleared at reset and at the end of each literal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_dims   <= '0;
            r_frozen <= 1'b0;
            r_want   <= 1'b0;
            r_total  <= '0;
            r_known  <= '0;
        end else if (w_adv) begin
            if (n_done) begin
                r_depth  <= '0;
                r_dims   <= '0;
                r_frozen <= 1'b0;
                r_want   <= 1'b0;
                r_total  <= '0;
                r_known  <= '0;
            end else begin
                r_depth  <= n_depth;
                r_dims   <= n_dims;
                r_frozen <= n_frozen;
                r_want   <= n_want;
                r_total  <= n_total;
                if (w_learn) r_known[w_lvl] <= 1'b1;
            end
        end
    end

    // Count stack: push on open, pop with parent bump on close
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_push) begin
                for (int i = 1; i < MAX_DIMS; i++) r_cnt[i] <= r_cnt[i-1];
                r_cnt[0] <= '0;
            end else if (w_pop) begin
                for (int i = 0; i < MAX_DIMS - 1; i++) r_cnt[i] <= r_cnt[i+1];
                r_cnt[0] <= nasc_pkg::sat_inc(w_below);
            end else if (w_bump) begin
                r_cnt[0] <= nasc_pkg::sat_inc(r_cnt[0]);
            end
            if (w_learn) r_len[w_lvl] <= r_cnt[0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv) begin
            r_status   <= n_status;
            r_elem_vld <= n_elem_vld;
            r_elem     <= n_elem;
            r_idx      <= n_idx;
            r_done     <= n_done;
            r_dimc     <= n_dimc;
            r_tot      <= n_tot;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_status;
    assign o_element_valid = r_elem_vld;
    assign o_element_out   = r_elem;
    assign o_element_index = r_idx;
    assign o_literal_done  = r_done;
    assign o_dim_count     = r_dimc;
    assign o_total_items   = r_tot;

endmodule

### design/nasc_checker.sv
// Port-level checks for the nested array shape checker, bound to the top level.
module nasc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [2:0]                   o_status,
    input logic                         o_element_valid,
    input logic [nasc_pkg::ELEM_W-1:0]  o_element_out,
    input logic [nasc_pkg::IDX_W-1:0]   o_element_index,
    input logic                         o_literal_done,
    input logic [nasc_pkg::TOTAL_W-1:0] o_total_items
);

    // An accepted element never comes with an error or an end of literal
    a_elem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_element_valid |->
            o_status == nasc_pkg::ST_OK && !o_literal_done)
        else $error("element passed with error or done");

    // No element: pass-through fields are zero
    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_element_valid |->
            o_element_out == '0 && o_element_index == '0)
        else $error("element fields nonzero without element");

    // Any error ends the literal
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != nasc_pkg::ST_OK |-> o_literal_done)
        else $error("error without literal_done");

    // Running total is one past the index of the element just passed
    a_idx_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_element_valid |->
            o_total_items[nasc_pkg::IDX_W-1:0] == 16'(o_element_index + 16'd1))
        else $error("element index and total disagree");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_element_out) &&
            $stable(o_element_index) && $stable(o_total_items))
        else $error("stalled result changed");

endmodule

bind nested_array_shape_checker nasc_checker u_nasc_checker (.*);
